/* rtl/bbd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the bilinear Bayer demosaic block.
// No dependencies; used by the top level and its checker.

package bbd_pkg;

   localparam int RAW_W        = 8;
   localparam int COLOUR_W     = 8;
   localparam int POS_W        = 10;
   localparam int CFG_DATA_W   = 11;
   localparam int CSR_INDEX_W  = 4;
   localparam int RSP_DATA_W   = 48;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 1024;
   localparam int WIDTH_RESET        = 424;
   localparam int HEIGHT_RESET       = 636;
   localparam int SIZE_MIN           = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   // Which of the up to four pixels released by one raw sample is being sent.
   typedef enum logic [1:0] {
      KIND_PREV_ROW_PREV_COL = 2'd0,
      KIND_PREV_ROW_THIS_COL = 2'd1,
      KIND_THIS_ROW_PREV_COL = 2'd2,
      KIND_THIS_ROW_THIS_COL = 2'd3
   } result_kind_type;

endpackage

`default_nettype wire

/* rtl/bilinear_bayer_demosaic_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Bilinear demosaic of an RGGB Bayer stream: line memory, 3x3 window, result register.
// Depends on bbd_pkg.

// Raw samples enter in raster order, red at the origin, one beat per clock unless
// stalled. Each sample at row r >= 1, column c >= 1 releases the RGB pixel at
// (r-1, c-1); at the last column it also releases (r-1, W-1), and in the last row
// the same columns of row r follow. The sustained rate is one sample per clock while
// the output is not held: the result register sends one pixel a cycle, so the input
// stalls at the end of each row after the first and at each sample past column 0 in
// the last row. A sample waits in its own register, then enters the window and job
// registers; its pixels leave through the result register. Both previous rows live
// in one line memory of MAX_WIDTH words, read at the sample's column and written
// back when the sample enters the window. Borders mirror without repeating the edge.
// Sizes clamp to [3, MAX]. A width or height register write restarts the frame at
// (0, 0); the user must make it only while idle, which the block does not enforce.

module bilinear_bayer_demosaic_top #(
   parameter int MAX_WIDTH  = bbd_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = bbd_pkg::MAX_HEIGHT_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // raw_pixel [7:0]
   input  wire logic [bbd_pkg::RAW_W-1:0]           req_tdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // out_row [9:0], out_col [19:10], red [27:20], green [35:28], blue [43:36], zero pad
   output logic [bbd_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic                                     rsp_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [bbd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [bbd_pkg::CFG_DATA_W-1:0]      csr_data
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int PW = bbd_pkg::RAW_W;
   localparam int WidthResetLast =
      ((bbd_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : bbd_pkg::WIDTH_RESET) - 1;
   localparam int HeightResetLast =
      ((bbd_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : bbd_pkg::HEIGHT_RESET) - 1;

   // Size registers hold the clamped size minus one.
   logic [CW-1:0] col_last_ff, col_last_in;
   logic [RW-1:0] row_last_ff, row_last_in;
   logic          csr_write;

   // Position of the next sample.
   logic [CW-1:0] cnt_col_ff, cnt_col_in;
   logic [RW-1:0] cnt_row_ff, cnt_row_in;

   // Line memory word: newer row in the upper byte, older row in the lower.
   logic [2*PW-1:0] line_mem [MAX_WIDTH];
   logic [2*PW-1:0] line_rd_ff;
   logic [CW-1:0]   line_rd_addr;

   // Sample waiting for its line memory data.
   logic          b_valid_ff, b_valid_in;
   logic [PW-1:0] b_pix_ff;
   logic [CW-1:0] b_col_ff;
   logic [RW-1:0] b_row_ff;

   // Window and the job of releasing pixels.
   logic [PW-1:0]            win_ff [3][3];
   logic                     job_valid_ff, job_valid_in;
   logic                     job_emit_ff;
   logic                     job_ecol_ff;
   logic                     job_erow_ff;
   logic                     job_top2_ff;
   logic                     job_lc2_ff;
   logic [CW-1:0]            job_col_ff;
   logic [RW-1:0]            job_row_ff;
   bbd_pkg::result_kind_type job_kind_ff, job_kind_in, kind_next;
   logic                     kind_last;

   logic accept, out_load, job_done, c_free, b_adv;

   // Result register.
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic                          rsp_tlast_ff;
   logic [bbd_pkg::RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // ---------------------------------------------------------------- control
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign out_load   = !rsp_tvalid_ff || rsp_tready;
   assign job_done   = job_valid_ff && (!job_emit_ff || (out_load && kind_last));
   assign c_free     = !job_valid_ff || job_done;
   assign b_adv      = b_valid_ff && c_free;
   assign req_tready = !b_valid_ff || c_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      col_last_in = col_last_ff;
      row_last_in = row_last_ff;
      if (csr_write && csr_index == bbd_pkg::REG_IMAGE_WIDTH) begin
         if (csr_data < bbd_pkg::CFG_DATA_W'(bbd_pkg::SIZE_MIN)) begin
            col_last_in = CW'(bbd_pkg::SIZE_MIN - 1);
         end else if (32'(csr_data) > 32'(MAX_WIDTH)) begin
            col_last_in = CW'(MAX_WIDTH - 1);
         end else begin
            col_last_in = CW'(csr_data - bbd_pkg::CFG_DATA_W'(1));
         end
      end
      if (csr_write && csr_index == bbd_pkg::REG_IMAGE_HEIGHT) begin
         if (csr_data < bbd_pkg::CFG_DATA_W'(bbd_pkg::SIZE_MIN)) begin
            row_last_in = RW'(bbd_pkg::SIZE_MIN - 1);
         end else if (32'(csr_data) > 32'(MAX_HEIGHT)) begin
            row_last_in = RW'(MAX_HEIGHT - 1);
         end else begin
            row_last_in = RW'(csr_data - bbd_pkg::CFG_DATA_W'(1));
         end
      end
   end

   always_comb begin
      cnt_col_in = cnt_col_ff;
      cnt_row_in = cnt_row_ff;
      if (csr_write && (csr_index == bbd_pkg::REG_IMAGE_WIDTH ||
                        csr_index == bbd_pkg::REG_IMAGE_HEIGHT)) begin
         cnt_col_in = '0;
         cnt_row_in = '0;
      end else if (accept) begin
         if (cnt_col_ff == col_last_ff) begin
            cnt_col_in = '0;
            cnt_row_in = (cnt_row_ff == row_last_ff) ? '0 : cnt_row_ff + RW'(1);
         end else begin
            cnt_col_in = cnt_col_ff + CW'(1);
         end
      end
   end

   assign b_valid_in = accept || (b_valid_ff && !c_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff <= CW'(WidthResetLast);
         row_last_ff <= RW'(HeightResetLast);
         cnt_col_ff  <= '0;
         cnt_row_ff  <= '0;
         b_valid_ff  <= 1'b0;
      end else begin
         col_last_ff <= col_last_in;
         row_last_ff <= row_last_in;
         cnt_col_ff  <= cnt_col_in;
         cnt_row_ff  <= cnt_row_in;
         b_valid_ff  <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_pix_ff <= req_tdata;
         b_col_ff <= cnt_col_ff;
         b_row_ff <= cnt_row_ff;
      end
   end

   // ------------------------------------------------------------ line memory
   // Re-read the waiting sample's column while it is held, so the data stays fresh.
   assign line_rd_addr = accept ? cnt_col_ff : b_col_ff;

   always_ff @(posedge clock) begin
      line_rd_ff <= line_mem[line_rd_addr];
      if (b_adv) begin
         line_mem[b_col_ff] <= {b_pix_ff, line_rd_ff[2*PW-1:PW]};
      end
   end

   // ------------------------------------------------------------- window/job
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (b_adv) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= line_rd_ff[PW-1:0];
         win_ff[1][2] <= line_rd_ff[2*PW-1:PW];
         win_ff[2][2] <= b_pix_ff;
      end
   end

   always_comb begin
      kind_next = bbd_pkg::KIND_PREV_ROW_PREV_COL;
      kind_last = 1'b1;
      case (job_kind_ff)
         bbd_pkg::KIND_PREV_ROW_PREV_COL: begin
            if (job_ecol_ff) begin
               kind_next = bbd_pkg::KIND_PREV_ROW_THIS_COL;
               kind_last = 1'b0;
            end else if (job_erow_ff) begin
               kind_next = bbd_pkg::KIND_THIS_ROW_PREV_COL;
               kind_last = 1'b0;
            end
         end
         bbd_pkg::KIND_PREV_ROW_THIS_COL: begin
            if (job_erow_ff) begin
               kind_next = bbd_pkg::KIND_THIS_ROW_PREV_COL;
               kind_last = 1'b0;
            end
         end
         bbd_pkg::KIND_THIS_ROW_PREV_COL: begin
            if (job_ecol_ff) begin
               kind_next = bbd_pkg::KIND_THIS_ROW_THIS_COL;
               kind_last = 1'b0;
            end
         end
         default: begin
            kind_last = 1'b1;
         end
      endcase
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      job_kind_in  = job_kind_ff;
      if (b_adv) begin
         job_valid_in = 1'b1;
         job_kind_in  = bbd_pkg::KIND_PREV_ROW_PREV_COL;
      end else if (job_done) begin
         job_valid_in = 1'b0;
      end else if (job_valid_ff && job_emit_ff && out_load) begin
         job_kind_in = kind_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         job_kind_ff  <= bbd_pkg::KIND_PREV_ROW_PREV_COL;
      end else begin
         job_valid_ff <= job_valid_in;
         job_kind_ff  <= job_kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         job_emit_ff <= (b_row_ff != '0) && (b_col_ff != '0);
         job_ecol_ff <= (b_col_ff == col_last_ff);
         job_erow_ff <= (b_row_ff == row_last_ff);
         job_top2_ff <= (b_row_ff == RW'(1));
         job_lc2_ff  <= (b_col_ff == CW'(1));
         job_col_ff  <= b_col_ff;
         job_row_ff  <= b_row_ff;
      end
   end

   // --------------------------------------------------------- interpolation
   logic [1:0]            rs [3];
   logic [1:0]            cs [3];
   logic [PW-1:0]         nb [3][3];
   logic                  this_row, this_col;
   logic [RW-1:0]         pos_row;
   logic [CW-1:0]         pos_col;
   logic [PW+1:0]         cross_sum, diag_sum;
   logic [PW:0]           horiz_sum, vert_sum;
   logic [PW-1:0]         red, green, blue;

   assign this_row = (job_kind_ff == bbd_pkg::KIND_THIS_ROW_PREV_COL) ||
                     (job_kind_ff == bbd_pkg::KIND_THIS_ROW_THIS_COL);
   assign this_col = (job_kind_ff == bbd_pkg::KIND_PREV_ROW_THIS_COL) ||
                     (job_kind_ff == bbd_pkg::KIND_THIS_ROW_THIS_COL);
   assign pos_row  = this_row ? job_row_ff : job_row_ff - RW'(1);
   assign pos_col  = this_col ? job_col_ff : job_col_ff - CW'(1);

   // Mirror at the borders by picking window rows and columns.
   always_comb begin
      if (this_row) begin
         rs[0] = 2'd1; rs[1] = 2'd2; rs[2] = 2'd1;
      end else begin
         rs[0] = job_top2_ff ? 2'd2 : 2'd0; rs[1] = 2'd1; rs[2] = 2'd2;
      end
      if (this_col) begin
         cs[0] = 2'd1; cs[1] = 2'd2; cs[2] = 2'd1;
      end else begin
         cs[0] = job_lc2_ff ? 2'd2 : 2'd0; cs[1] = 2'd1; cs[2] = 2'd2;
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            nb[i][j] = win_ff[rs[i]][cs[j]];
         end
      end
   end

   assign cross_sum = (PW+2)'(nb[0][1]) + (PW+2)'(nb[2][1]) +
                      (PW+2)'(nb[1][0]) + (PW+2)'(nb[1][2]);
   assign diag_sum  = (PW+2)'(nb[0][0]) + (PW+2)'(nb[0][2]) +
                      (PW+2)'(nb[2][0]) + (PW+2)'(nb[2][2]);
   assign horiz_sum = (PW+1)'(nb[1][0]) + (PW+1)'(nb[1][2]);
   assign vert_sum  = (PW+1)'(nb[0][1]) + (PW+1)'(nb[2][1]);

   always_comb begin
      case ({pos_row[0], pos_col[0]})
         2'b00: begin
            red   = nb[1][1];
            green = cross_sum[PW+1:2];
            blue  = diag_sum[PW+1:2];
         end
         2'b11: begin
            red   = diag_sum[PW+1:2];
            green = cross_sum[PW+1:2];
            blue  = nb[1][1];
         end
         2'b01: begin
            red   = horiz_sum[PW:1];
            green = nb[1][1];
            blue  = vert_sum[PW:1];
         end
         default: begin
            red   = vert_sum[PW:1];
            green = nb[1][1];
            blue  = horiz_sum[PW:1];
         end
      endcase
   end

   assign rsp_tdata_in = {4'd0, blue, green, red,
                          bbd_pkg::POS_W'(pos_col), bbd_pkg::POS_W'(pos_row)};

   // ------------------------------------------------------- result register
   assign rsp_tvalid_in = out_load ? (job_valid_ff && job_emit_ff) : rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tlast_ff <= kind_last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

`default_nettype wire

/* rtl/bbd_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks of the demosaic top level, bound to it below.
// Depends on bbd_pkg.

module bbd_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 rsp_tvalid,
   input wire logic                                 rsp_tready,
   input wire logic                                 rsp_tlast,
   input wire logic [bbd_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   // A stalled result beat holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // Pixels of one sample follow one another without a gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside the pixels of one sample");

   // Nothing comes out straight after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The padding above blue is always zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[bbd_pkg::RSP_DATA_W-1:44] == '0)
      else $error("result padding not zero");

   // A result is never valid as reset falls, since no sample can yet have reached the output.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid in first cycle out of reset");

endmodule

bind bilinear_bayer_demosaic_top bbd_checker u_bbd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* tb/bbd_demosaic_checker.sv */
`timescale 1ns / 1ps
// Checker for the bilinear Bayer demosaic: watches the raw, pixel and register channels,
// predicts every RGB pixel and compares each pixel beat with the oldest one predicted.
// Depends on bbd_pkg.

module bbd_demosaic_checker
   import bbd_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [RAW_W-1:0]       req_tdata,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                   rsp_tlast,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CFG_DATA_W-1:0]  csr_data,
   output int                          fail_count,
   output int                          pending_count
);

   localparam int COL_LSB   = POS_W;
   localparam int RED_LSB   = 2 * POS_W;
   localparam int GREEN_LSB = RED_LSB + COLOUR_W;
   localparam int BLUE_LSB  = GREEN_LSB + COLOUR_W;

   typedef struct packed {
      logic [POS_W-1:0]    row;
      logic [POS_W-1:0]    col;
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
      logic                run_end;
   } rgb_pixel_type;

   // rows r-2 and r-1 of the frame, indexed by column
   logic [RAW_W-1:0]      line_two_up [MAX_WIDTH];
   logic [RAW_W-1:0]      line_one_up [MAX_WIDTH];
   // 3x3 neighbourhood: rows r-2, r-1, r by columns c-2, c-1, c
   logic [RAW_W-1:0]      nbhd [9];
   logic [CFG_DATA_W-1:0] width_reg;
   logic [CFG_DATA_W-1:0] height_reg;
   int                    row_pos;
   int                    col_pos;
   int                    mismatches = 0;
   rgb_pixel_type         expected_pixels [$];

   function automatic int clamp_size(input logic [CFG_DATA_W-1:0] value, input int top);
      if (value < SIZE_MIN) return SIZE_MIN;
      if (value > top) return top;
      return int'(value);
   endfunction

   // ra..rc pick neighbourhood rows, ca..cc columns; mirrored borders reuse an index
   function automatic rgb_pixel_type interpolate(input int row, input int col,
                                                 input int ra, input int rb, input int rc,
                                                 input int ca, input int cb, input int cc);
      int            rs [3];
      int            cs [3];
      int            n [3][3];
      int            cross_sum;
      int            diag_sum;
      int            red;
      int            green;
      int            blue;
      rgb_pixel_type pix;
      rs[0] = ra; rs[1] = rb; rs[2] = rc;
      cs[0] = ca; cs[1] = cb; cs[2] = cc;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            n[i][j] = int'(nbhd[rs[i] * 3 + cs[j]]);
      cross_sum = n[0][1] + n[2][1] + n[1][0] + n[1][2];
      diag_sum  = n[0][0] + n[0][2] + n[2][0] + n[2][2];
      if (row[0] == 1'b0 && col[0] == 1'b0) begin
         red = n[1][1]; green = cross_sum / 4; blue = diag_sum / 4;
      end else if (row[0] == 1'b1 && col[0] == 1'b1) begin
         red = diag_sum / 4; green = cross_sum / 4; blue = n[1][1];
      end else if (row[0] == 1'b0) begin
         // green on a red row: blue comes from above and below
         red   = (n[1][0] + n[1][2]) / 2;
         green = n[1][1];
         blue  = (n[0][1] + n[2][1]) / 2;
      end else begin
         red   = (n[0][1] + n[2][1]) / 2;
         green = n[1][1];
         blue  = (n[1][0] + n[1][2]) / 2;
      end
      pix.row     = row[POS_W-1:0];
      pix.col     = col[POS_W-1:0];
      pix.red     = red[COLOUR_W-1:0];
      pix.green   = green[COLOUR_W-1:0];
      pix.blue    = blue[COLOUR_W-1:0];
      pix.run_end = 1'b0;
      return pix;
   endfunction

   task automatic predict_pixels(input logic [RAW_W-1:0] raw);
      int               w;
      int               h;
      int               r;
      int               c;
      int               lc;
      int               top;
      int               k;
      logic [RAW_W-1:0] up;
      logic [RAW_W-1:0] mid;
      rgb_pixel_type    found [4];
      w = clamp_size(width_reg, MAX_WIDTH);
      h = clamp_size(height_reg, MAX_HEIGHT);
      r = row_pos;
      c = col_pos;
      k = 0;
      if (c >= w) c = 0;
      if (r >= h) r = 0;
      up  = line_two_up[c];
      mid = line_one_up[c];
      line_two_up[c] = mid;
      line_one_up[c] = raw;
      for (int i = 0; i < 3; i++) begin
         nbhd[i * 3]     = nbhd[i * 3 + 1];
         nbhd[i * 3 + 1] = nbhd[i * 3 + 2];
      end
      nbhd[2] = up;
      nbhd[5] = mid;
      nbhd[8] = raw;
      if (r >= 1 && c >= 1) begin
         lc  = (c == 1) ? 2 : 0;
         top = (r == 1) ? 2 : 0;
         found[k] = interpolate(r - 1, c - 1, top, 1, 2, lc, 1, 2);
         k++;
         if (c == w - 1) begin
            found[k] = interpolate(r - 1, c, top, 1, 2, 1, 2, 1);
            k++;
         end
         // last row: this row's pixels follow those of the row above
         if (r == h - 1) begin
            found[k] = interpolate(r, c - 1, 1, 2, 1, lc, 1, 2);
            k++;
            if (c == w - 1) begin
               found[k] = interpolate(r, c, 1, 2, 1, 1, 2, 1);
               k++;
            end
         end
      end
      if (k > 0) found[k - 1].run_end = 1'b1;
      for (int i = 0; i < k; i++) expected_pixels.push_back(found[i]);
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      row_pos = r;
      col_pos = c;
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      rgb_pixel_type want;
      if (reset) begin
         for (int i = 0; i < MAX_WIDTH; i++) begin
            line_two_up[i] = '0;
            line_one_up[i] = '0;
         end
         for (int i = 0; i < 9; i++) nbhd[i] = '0;
         width_reg  = CFG_DATA_W'(WIDTH_RESET);
         height_reg = CFG_DATA_W'(HEIGHT_RESET);
         row_pos    = 0;
         col_pos    = 0;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_IMAGE_WIDTH: begin
                  width_reg = csr_data;
                  row_pos   = 0;
                  col_pos   = 0;
               end
               REG_IMAGE_HEIGHT: begin
                  height_reg = csr_data;
                  row_pos    = 0;
                  col_pos    = 0;
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_pixels(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $error("pixel beat with nothing expected: row %0d col %0d",
                      rsp_tdata[0 +: POS_W], rsp_tdata[COL_LSB +: POS_W]);
               mismatches++;
            end else begin
               want = expected_pixels.pop_front();
               compare_field("out_row", want.row, rsp_tdata[0 +: POS_W]);
               compare_field("out_col", want.col, rsp_tdata[COL_LSB +: POS_W]);
               compare_field("red", want.red, rsp_tdata[RED_LSB +: COLOUR_W]);
               compare_field("green", want.green, rsp_tdata[GREEN_LSB +: COLOUR_W]);
               compare_field("blue", want.blue, rsp_tdata[BLUE_LSB +: COLOUR_W]);
               compare_field("run_end", want.run_end, rsp_tlast);
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_pixels.size();
   end

endmodule

/* tb/bilinear_bayer_demosaic_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the bilinear Bayer demosaic: clock, reset, raw pixel stimulus,
// register writes and back-pressure. Depends on bbd_pkg, the block and bbd_demosaic_checker.

module bilinear_bayer_demosaic_top_tb;
   import bbd_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = CSR_INDEX_W'(9);
   localparam int                     SETTLE_CYCLES = 8;
   localparam longint                 TIMEOUT_NS = 25_000_000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [RAW_W-1:0]       req_tdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_DATA_W-1:0]  csr_data = '0;
   int                     fail_count;
   int                     pending_count;
   bit                     idle_on = 1'b1;

   bilinear_bayer_demosaic_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bbd_demosaic_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("status: fail");
      $finish;
   end

   // back-pressure on the pixel side in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [RAW_W-1:0] random_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return RAW_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixel(input logic [RAW_W-1:0] value);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_pixels(input int count);
      for (int i = 0; i < count; i++) send_pixel(random_pixel());
   endtask

   // drop valid, hold until every predicted pixel is back, then let the pipe empty
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CFG_DATA_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CFG_DATA_W-1:0] random_size(input int hi);
      // now and then a value below the minimum, which the block clamps
      if ($urandom_range(0, 3) == 0) return CFG_DATA_W'($urandom_range(0, 2));
      return CFG_DATA_W'($urandom_range(SIZE_MIN, hi));
   endfunction

   logic [RAW_W-1:0] corner_pixels [12] = '{
      8'h00, 8'hff, 8'h01, 8'hfe, 8'h80, 8'h7f, 8'h55, 8'haa, 8'hff, 8'h00, 8'hff, 8'h00
   };

   initial begin
      int count;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // smallest frame, both sizes given below the minimum
      write_csr(REG_IMAGE_WIDTH, CFG_DATA_W'(0));
      write_csr(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
      foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
      // unmapped index: neither the sizes nor the position may move
      write_csr(REG_UNMAPPED, '1);
      for (int i = 0; i < 6; i++) send_pixel(i[0] ? 8'hff : 8'h00);

      // widest row, given beyond the maximum; then a tall narrow frame
      write_csr(REG_IMAGE_WIDTH, '1);
      write_csr(REG_IMAGE_HEIGHT, CFG_DATA_W'(SIZE_MIN));
      send_pixels(20);
      write_csr(REG_IMAGE_WIDTH, CFG_DATA_W'(SIZE_MIN));
      write_csr(REG_IMAGE_HEIGHT, CFG_DATA_W'(MAX_HEIGHT_DEFAULT));
      send_pixels(30);

      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 3) idle_on = 1'b0;
         if ($urandom_range(0, 1) == 0) begin
            write_csr(REG_IMAGE_WIDTH, random_size(7));
            write_csr(REG_IMAGE_HEIGHT, random_size(5));
         end else begin
            write_csr(REG_IMAGE_HEIGHT, random_size(5));
            write_csr(REG_IMAGE_WIDTH, random_size(7));
         end
         count = $urandom_range(10, 20);
         send_pixels(count / 2);
         if (phase == 1) wait_drained();
         send_pixels(count - count / 2);
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
